FILE: rtl/core/frt_pkg.sv
// Shared constants, codes and types of the fragment reassembly tracker.
package frt_pkg;

  localparam int MAX_SLICES_DEF = 64;
  localparam int CHANNELS_DEF   = 256;

  localparam int IDX_MAX_W = 6;
  localparam int CNT_W     = 7;
  localparam int TOTAL_W   = 16;
  localparam int TIME_W    = 32;
  localparam int CHAN_W    = 8;

  localparam logic [15:0] TIMEOUT_RST = 16'd80;

  typedef enum logic [1:0] {
    EV_LOST   = 2'd0,
    EV_DONE   = 2'd1,
    EV_REJECT = 2'd2
  } event_e;

  typedef struct packed {
    logic                 reject;
    logic [CHAN_W-1:0]    ch;
    logic [IDX_MAX_W-1:0] idx;
    logic [TOTAL_W-1:0]   total;
    logic [TIME_W-1:0]    arrival;
  } pkt_t;

  typedef struct packed {
    event_e            ev;
    logic [CHAN_W-1:0] ch;
    logic [CNT_W-1:0]  held;
    logic              last;
  } res_t;

endpackage

FILE: rtl/core/frt_if.sv
// Request and event channel interfaces of the fragment reassembly tracker.
interface frt_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] head_word;
  logic [7:0]  tail_byte;
  logic [7:0]  channel;
  logic [15:0] slice_index;
  logic [15:0] slice_total;
  logic [31:0] time_ms;

  modport source (output valid, head_word, tail_byte, channel, slice_index, slice_total,
                  time_ms, input ready);
  modport sink (input valid, head_word, tail_byte, channel, slice_index, slice_total,
                time_ms, output ready);
endinterface

interface frt_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] event_channel;
  logic [6:0] slices_held;
  logic       last;

  modport source (output valid, event_res, event_channel, slices_held, last, input ready);
  modport sink (input valid, event_res, event_channel, slices_held, last, output ready);
endinterface

FILE: rtl/core/frt_fifo.sv
// Small register FIFO with a power-of-two depth.
module frt_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         full_o,
  output logic         empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] buf_q [DEPTH];
  logic [PW:0]  wr_ptr_q, wr_ptr_d;
  logic [PW:0]  rd_ptr_q, rd_ptr_d;

  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign full_o  = (wr_ptr_q[PW] != rd_ptr_q[PW]) && (wr_ptr_q[PW-1:0] == rd_ptr_q[PW-1:0]);
  assign data_o  = buf_q[rd_ptr_q[PW-1:0]];

  assign wr_ptr_d = (push_i && !full_o) ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = (pop_i && !empty_o) ? rd_ptr_q + 1'b1 : rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      buf_q[wr_ptr_q[PW-1:0]] <= data_i;
    end
  end

endmodule

FILE: rtl/core/frt_front.sv
// Front end: checks the marks and the channel range, flags bad indexes and queues requests.
module frt_front #(
  parameter int MAX_SLICES = frt_pkg::MAX_SLICES_DEF,
  parameter int CHANNELS   = frt_pkg::CHANNELS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    head_magic_i,
  input  logic [7:0]     tail_magic_i,
  frt_req_if.sink        req_i,
  input  logic           pkt_pop_i,
  output frt_pkg::pkt_t  pkt_o,
  output logic           pkt_empty_o
);

  localparam int QUEUE_DEPTH = 2;

  logic          q_full;
  logic          keep;
  frt_pkg::pkt_t pkt_in;

  assign req_i.ready = !q_full;

  // Requests with wrong marks or an unknown channel are taken and dropped here.
  assign keep = (req_i.head_word == head_magic_i) && (req_i.tail_byte == tail_magic_i) &&
                (32'(req_i.channel) < CHANNELS);

  always_comb begin
    pkt_in.reject  = (32'(req_i.slice_index) >= MAX_SLICES);
    pkt_in.ch      = req_i.channel;
    pkt_in.idx     = req_i.slice_index[frt_pkg::IDX_MAX_W-1:0];
    pkt_in.total   = req_i.slice_total;
    pkt_in.arrival = req_i.time_ms;
  end

  frt_fifo #(
    .W     ($bits(frt_pkg::pkt_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (req_i.valid && keep),
    .data_i  (pkt_in),
    .pop_i   (pkt_pop_i),
    .data_o  (pkt_o),
    .full_o  (q_full),
    .empty_o (pkt_empty_o)
  );

endmodule

FILE: rtl/core/frt_back.sv
// Back end: per-channel state memory, read-modify-write sequencer and event queue.
module frt_back #(
  parameter int MAX_SLICES = frt_pkg::MAX_SLICES_DEF,
  parameter int CHANNELS   = frt_pkg::CHANNELS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [15:0]   timeout_i,
  input  frt_pkg::pkt_t pkt_i,
  input  logic          pkt_empty_i,
  output logic          pkt_pop_o,
  frt_evt_if.source     evt_o
);

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W   = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int CNT_W   = frt_pkg::CNT_W;
  localparam int TOT_W   = frt_pkg::TOTAL_W;
  localparam int TIM_W   = frt_pkg::TIME_W;
  localparam int EXP_LO  = TIM_W;
  localparam int CNT_LO  = EXP_LO + TOT_W;
  localparam int MAP_LO  = CNT_LO + CNT_W;
  localparam int ENTRY_W = MAP_LO + MAX_SLICES;
  localparam int OUT_DEPTH = 2;

  localparam logic [1:0] ST_READ = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_PEND = 2'd2;

  logic [ENTRY_W-1:0] mem_q [CHANNELS];
  logic [CHANNELS-1:0] valid_q;
  logic [ENTRY_W-1:0] rd_q;
  logic               rd_vld_q;
  logic [CH_W-1:0]    rd_addr;
  logic [CH_W-1:0]    wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               mem_we;

  logic [1:0]     state_q, state_d;
  frt_pkg::pkt_t  cur_q, cur_d;
  frt_pkg::res_t  pend_q, pend_d;
  frt_pkg::res_t  res;
  frt_pkg::res_t  res_out;
  logic           res_push;
  logic           out_full;
  logic           out_empty;

  logic [ENTRY_W-1:0]    entry;
  logic [MAX_SLICES-1:0] map0, map1, map2;
  logic [CNT_W-1:0]      cnt0, cnt1, cnt2;
  logic [TOT_W-1:0]      exp0;
  logic [TIM_W-1:0]      last0, gap;
  logic [IDX_W-1:0]      idx;
  logic                  lost, done, hit;
  frt_pkg::res_t         lost_res, done_res, rej_res;

  assign rd_addr = pkt_i.ch[CH_W-1:0];
  assign wr_addr = cur_q.ch[CH_W-1:0];
  assign idx     = cur_q.idx[IDX_W-1:0];

  // An entry never written since reset reads as all zero.
  assign entry = rd_vld_q ? rd_q : '0;
  assign map0  = entry[ENTRY_W-1:MAP_LO];
  assign cnt0  = entry[MAP_LO-1:CNT_LO];
  assign exp0  = entry[CNT_LO-1:EXP_LO];
  assign last0 = entry[EXP_LO-1:0];

  always_comb begin
    gap  = cur_q.arrival - last0;
    lost = (cnt0 != '0) &&
           ((idx == '0) || ((exp0 != '0) && (cur_q.total != exp0)) ||
            (gap > TIM_W'(timeout_i)));
    map1 = lost ? '0 : map0;
    cnt1 = lost ? '0 : cnt0;
    hit  = map1[idx];
    map2 = map1 | (MAX_SLICES'(1) << idx);
    cnt2 = cnt1 + CNT_W'(!hit);
    done = (TOT_W'(cnt2) == cur_q.total);

    wr_data = done ? {{MAX_SLICES{1'b0}}, {CNT_W{1'b0}}, {TOT_W{1'b0}}, cur_q.arrival}
                   : {map2, cnt2, cur_q.total, cur_q.arrival};

    lost_res.ev   = frt_pkg::EV_LOST;
    lost_res.ch   = cur_q.ch;
    lost_res.held = cnt0;
    lost_res.last = !done;

    done_res.ev   = frt_pkg::EV_DONE;
    done_res.ch   = cur_q.ch;
    done_res.held = cnt2;
    done_res.last = 1'b1;

    rej_res.ev    = frt_pkg::EV_REJECT;
    rej_res.ch    = cur_q.ch;
    rej_res.held  = cnt0;
    rej_res.last  = 1'b1;
  end

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    pend_d    = pend_q;
    pkt_pop_o = 1'b0;
    mem_we    = 1'b0;
    res_push  = 1'b0;
    res       = rej_res;
    case (state_q)
      ST_READ: begin
        if (!pkt_empty_i) begin
          pkt_pop_o = 1'b1;
          cur_d     = pkt_i;
          state_d   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_full) begin
          state_d = ST_READ;
          if (cur_q.reject) begin
            res_push = 1'b1;
            res      = rej_res;
          end else begin
            mem_we   = 1'b1;
            res_push = lost || done;
            res      = lost ? lost_res : done_res;
            if (lost && done) begin
              pend_d  = done_res;
              state_d = ST_PEND;
            end
          end
        end
      end
      ST_PEND: begin
        if (!out_full) begin
          res_push = 1'b1;
          res      = pend_q;
          state_d  = ST_READ;
        end
      end
      default: begin
        state_d = ST_READ;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_READ;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    pend_q <= pend_d;
    if (pkt_pop_o) begin
      rd_q     <= mem_q[rd_addr];
      rd_vld_q <= valid_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  frt_fifo #(
    .W     ($bits(frt_pkg::res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .pop_i   (evt_o.valid && evt_o.ready),
    .data_o  (res_out),
    .full_o  (out_full),
    .empty_o (out_empty)
  );

  assign evt_o.valid         = !out_empty;
  assign evt_o.event_res     = res_out.ev;
  assign evt_o.event_channel = res_out.ch;
  assign evt_o.slices_held   = res_out.held;
  assign evt_o.last          = res_out.last;

endmodule

FILE: rtl/core/fragment_reassembly_tracker.sv
// Top level of the fragment reassembly tracker with its configuration registers.
//
//   Channel  Direction  Handshake          Carries
//   req_i    in         valid / ready      one packet header per request
//   evt_o    out        valid / ready      one loss, completion or reject event
//   APB      in / out   psel / penable     head_magic, tail_magic, timeout_ms
//
// A kept request passes through the back-end states in order: ST_READ reads the channel memory,
// ST_EXEC updates and writes back once the event queue has room, and ST_PEND follows when the
// request yields both a loss and a completion event. Dropped requests never reach the back end.
// Reset clears the valid bit of every channel at once, so there is no clearing pass.
// A two-entry request queue and a two-entry event queue let both sides stall on their own.
module fragment_reassembly_tracker #(
  parameter int MAX_SLICES = frt_pkg::MAX_SLICES_DEF,
  parameter int CHANNELS   = frt_pkg::CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  frt_req_if.sink     req_i,
  frt_evt_if.source   evt_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_HEAD    = 2'd0;
  localparam logic [1:0] REG_TAIL    = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  logic [15:0]   head_magic_q;
  logic [7:0]    tail_magic_q;
  logic [15:0]   timeout_q;
  logic          wr_en;
  frt_pkg::pkt_t pkt;
  logic          pkt_empty;
  logic          pkt_pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_magic_q <= '0;
      tail_magic_q <= '0;
      timeout_q    <= frt_pkg::TIMEOUT_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_HEAD:    head_magic_q <= pwdata[15:0];
        REG_TAIL:    tail_magic_q <= pwdata[7:0];
        REG_TIMEOUT: timeout_q    <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HEAD:    prdata = {16'd0, head_magic_q};
      REG_TAIL:    prdata = {24'd0, tail_magic_q};
      REG_TIMEOUT: prdata = {16'd0, timeout_q};
      default:     prdata = '0;
    endcase
  end

  frt_front #(
    .MAX_SLICES (MAX_SLICES),
    .CHANNELS   (CHANNELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_magic_i (head_magic_q),
    .tail_magic_i (tail_magic_q),
    .req_i        (req_i),
    .pkt_pop_i    (pkt_pop),
    .pkt_o        (pkt),
    .pkt_empty_o  (pkt_empty)
  );

  frt_back #(
    .MAX_SLICES (MAX_SLICES),
    .CHANNELS   (CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .timeout_i   (timeout_q),
    .pkt_i       (pkt),
    .pkt_empty_i (pkt_empty),
    .pkt_pop_o   (pkt_pop),
    .evt_o       (evt_o)
  );

endmodule

FILE: tb/sv/fragment_reassembly_tracker_test.sv
// Self-checking testbench of the fragment reassembly tracker: header driver, event monitor.
`timescale 1ns / 100ps

module fragment_reassembly_tracker_test;

  localparam logic [3:0] REG_HEAD_MAGIC = 4'h0;
  localparam logic [3:0] REG_TAIL_MAGIC = 4'h4;
  localparam logic [3:0] REG_TIMEOUT_MS = 4'h8;

  localparam int unsigned CYCLE_LIMIT      = 1_000_000;
  localparam int unsigned SETTLE_CYCLES    = 32;
  localparam int unsigned HOLDOFF_CYCLES   = 600;
  localparam int unsigned HOLDOFF_AFTER    = 100;
  localparam int unsigned RANDOM_PER_PHASE = 490;
  localparam int unsigned PRINT_CAP        = 20;

  typedef enum logic [1:0] {
    FLAW_NONE,
    FLAW_TRUNCATE,
    FLAW_TOTAL,
    FLAW_LATE
  } flaw_e;

  typedef struct {
    logic [15:0] head_word;
    logic [7:0]  tail_byte;
    logic [7:0]  channel;
    logic [15:0] slice_index;
    logic [15:0] slice_total;
    logic [31:0] time_ms;
    int unsigned gap;
  } header_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  frt_req_if req_bus ();
  frt_evt_if evt_bus ();

  fragment_reassembly_tracker u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_bus),
    .evt_o   (evt_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  logic [15:0] cfg_head_magic;
  logic [7:0]  cfg_tail_magic;
  logic [15:0] cfg_timeout_ms;

  logic [63:0] seen_map    [frt_pkg::CHANNELS_DEF];
  logic [6:0]  held_cnt    [frt_pkg::CHANNELS_DEF];
  logic [15:0] frame_total [frt_pkg::CHANNELS_DEF];
  logic [31:0] last_time   [frt_pkg::CHANNELS_DEF];

  header_t       header_queue [$];
  frt_pkg::res_t pending_events [$];
  header_t       in_flight;
  frt_pkg::res_t want;
  logic [31:0]   clock_ms;

  int unsigned headers_queued   = 0;
  int unsigned headers_accepted = 0;
  int unsigned events_seen      = 0;
  int unsigned mismatches       = 0;
  int unsigned cycle_count      = 0;
  int unsigned gap_count        = 0;
  int unsigned send_calm        = 0;
  int unsigned sink_calm        = 0;
  int unsigned sink_stall       = 0;
  int unsigned hold_left        = 0;
  bit          holdoff_done     = 1'b0;
  bit          sink_holding     = 1'b0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 99) < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic frt_pkg::res_t make_event(input frt_pkg::event_e ev,
                                               input logic [7:0] ch,
                                               input logic [6:0] held, input logic last);
    frt_pkg::res_t r;
    r.ev   = ev;
    r.ch   = ch;
    r.held = held;
    r.last = last;
    return r;
  endfunction

  function automatic void track_header(input header_t h);
    frt_pkg::res_t loss_ev;
    logic          lost;
    logic [31:0]   elapsed;
    logic [7:0]    ch;
    ch = h.channel;
    if (h.head_word != cfg_head_magic || h.tail_byte != cfg_tail_magic) return;
    if (int'(ch) >= frt_pkg::CHANNELS_DEF) return;
    if (h.slice_index >= frt_pkg::MAX_SLICES_DEF) begin
      pending_events = {pending_events,
                        make_event(frt_pkg::EV_REJECT, ch, held_cnt[ch], 1'b1)};
      return;
    end
    lost = 1'b0;
    elapsed = h.time_ms - last_time[ch];
    if (held_cnt[ch] != 0) begin
      if (h.slice_index == 0) begin
        lost = 1'b1;
      end else if (frame_total[ch] != 0 && h.slice_total != frame_total[ch]) begin
        lost = 1'b1;
      end else if (elapsed > {16'd0, cfg_timeout_ms}) begin
        lost = 1'b1;
      end
    end
    loss_ev = make_event(frt_pkg::EV_LOST, ch, held_cnt[ch], 1'b1);
    if (lost) begin
      seen_map[ch] = '0;
      held_cnt[ch] = '0;
    end
    frame_total[ch] = h.slice_total;
    last_time[ch]   = h.time_ms;
    if (!seen_map[ch][h.slice_index[5:0]]) begin
      seen_map[ch][h.slice_index[5:0]] = 1'b1;
      held_cnt[ch] = held_cnt[ch] + 7'd1;
    end
    if ({9'd0, held_cnt[ch]} == frame_total[ch]) begin
      if (lost) begin
        loss_ev.last = 1'b0;
        pending_events = {pending_events, loss_ev};
      end
      pending_events = {pending_events,
                        make_event(frt_pkg::EV_DONE, ch, held_cnt[ch], 1'b1)};
      seen_map[ch]    = '0;
      held_cnt[ch]    = '0;
      frame_total[ch] = '0;
    end else if (lost) begin
      pending_events = {pending_events, loss_ev};
    end
  endfunction

  function automatic void queue_packet(input logic [15:0] hw, input logic [7:0] tb,
                                       input logic [7:0] ch, input logic [15:0] idx,
                                       input logic [15:0] total, input logic [31:0] t);
    header_t h;
    h.head_word   = hw;
    h.tail_byte   = tb;
    h.channel     = ch;
    h.slice_index = idx;
    h.slice_total = total;
    h.time_ms     = t;
    h.gap         = draw_wait(send_calm);
    header_queue = {header_queue, h};
    headers_queued++;
  endfunction

  task automatic apb_access(input logic wr, input logic [3:0] addr, input logic [31:0] data,
                            output logic [31:0] rd);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_settings(input logic [15:0] hm, input logic [7:0] tm,
                                input logic [15:0] tmo);
    logic [3:0]  addrs [3];
    logic [31:0] vals  [3];
    logic [31:0] rd;
    addrs = '{REG_HEAD_MAGIC, REG_TAIL_MAGIC, REG_TIMEOUT_MS};
    vals  = '{{16'd0, hm}, {24'd0, tm}, {16'd0, tmo}};
    for (int i = 0; i < 3; i++) begin
      apb_access(1'b1, addrs[i], vals[i], rd);
      apb_access(1'b0, addrs[i], 32'd0, rd);
      if (rd !== vals[i]) begin
        report_mismatch($sformatf("register 0x%0h reads 0x%0h, expected 0x%0h",
                                  addrs[i], rd, vals[i]));
      end
    end
    cfg_head_magic = hm;
    cfg_tail_magic = tm;
    cfg_timeout_ms = tmo;
  endtask

  task automatic wait_idle();
    while (headers_accepted != headers_queued || pending_events.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random_phase(input int unsigned budget);
    int unsigned good, tmo, r, n, stop, flaw_at;
    int          j, k;
    flaw_e       flaw;
    logic [15:0] total, tot_sent, idx, head;
    logic [7:0]  ch, tail;
    logic [15:0] slot [64];
    good     = 0;
    tmo      = cfg_timeout_ms;
    clock_ms = $urandom;
    while (good < budget) begin
      r  = $urandom_range(0, 99);
      ch = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
      if (r < 75) begin
        r = $urandom_range(0, 99);
        if (r < 75) total = 16'($urandom_range(1, 8));
        else if (r < 92) total = 16'($urandom_range(9, frt_pkg::MAX_SLICES_DEF));
        else if (r < 96) total = '0;
        else total = 16'($urandom_range(frt_pkg::MAX_SLICES_DEF + 1, 65535));
        if (total != 0 && total <= frt_pkg::MAX_SLICES_DEF) begin
          n = total;
          for (j = 0; j < n; j++) slot[j] = 16'(j);
        end else begin
          n = $urandom_range(1, 6);
          for (j = 0; j < n; j++) begin
            slot[j] = 16'($urandom_range(0, frt_pkg::MAX_SLICES_DEF - 1));
          end
        end
        r = $urandom_range(0, 99);
        if (r >= 60) begin
          for (j = n - 1; j >= 1; j--) begin
            k = (r < 90) ? $urandom_range(1, j) : $urandom_range(0, j);
            idx     = slot[j];
            slot[j] = slot[k];
            slot[k] = idx;
          end
        end
        r = $urandom_range(0, 19);
        flaw = (r < 16) ? FLAW_NONE : (r < 18) ? FLAW_TRUNCATE : (r == 18) ? FLAW_TOTAL
                                                                           : FLAW_LATE;
        flaw_at = $urandom_range(0, n - 1);
        stop = (flaw == FLAW_TRUNCATE) ? flaw_at : n;
        for (j = 0; j < stop && good < budget; j++) begin
          if (flaw == FLAW_LATE && j == flaw_at) clock_ms += tmo + 1 + $urandom_range(0, 1000);
          else clock_ms += $urandom_range(0, tmo);
          tot_sent = (flaw == FLAW_TOTAL && j == flaw_at) ?
                     total ^ 16'($urandom_range(1, 65535)) : total;
          queue_packet(cfg_head_magic, cfg_tail_magic, ch, slot[j], tot_sent, clock_ms);
          good++;
          if (j > 0 && $urandom_range(0, 19) == 0) begin
            queue_packet(cfg_head_magic, cfg_tail_magic, ch, slot[$urandom_range(0, j)],
                         total, clock_ms);
            good++;
          end
        end
      end else if (r < 90) begin
        if ($urandom_range(0, 1) == 0) begin
          head = cfg_head_magic;
          tail = cfg_tail_magic ^ 8'($urandom_range(1, 255));
        end else begin
          head = 16'($urandom);
          tail = 8'($urandom);
        end
        queue_packet(head, tail, ch, 16'($urandom), 16'($urandom), $urandom);
      end else begin
        idx = ($urandom_range(0, 1) == 0) ?
              16'($urandom_range(frt_pkg::MAX_SLICES_DEF, 65535)) : 16'($urandom);
        queue_packet(cfg_head_magic, cfg_tail_magic, ch, idx, 16'($urandom),
                     ($urandom_range(0, 1) == 0) ? clock_ms : $urandom);
        good++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
      gap_count = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        track_header(in_flight);
        headers_accepted++;
      end
      if (req_bus.valid && !req_bus.ready) begin
        gap_count = 0;
      end else if (header_queue.size() == 0) begin
        req_bus.valid <= 1'b0;
      end else if (gap_count < header_queue[0].gap && !sink_holding) begin
        gap_count++;
        req_bus.valid <= 1'b0;
      end else begin
        in_flight = header_queue.pop_front();
        gap_count = 0;
        req_bus.valid       <= 1'b1;
        req_bus.head_word   <= in_flight.head_word;
        req_bus.tail_byte   <= in_flight.tail_byte;
        req_bus.channel     <= in_flight.channel;
        req_bus.slice_index <= in_flight.slice_index;
        req_bus.slice_total <= in_flight.slice_total;
        req_bus.time_ms     <= in_flight.time_ms;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      evt_bus.ready <= 1'b0;
    end else begin
      if (evt_bus.valid && evt_bus.ready) begin
        events_seen++;
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event res=%0d ch=%0d held=%0d last=%0b",
                                    evt_bus.event_res, evt_bus.event_channel,
                                    evt_bus.slices_held, evt_bus.last));
        end else begin
          want = pending_events.pop_front();
          if (evt_bus.event_res != want.ev || evt_bus.event_channel != want.ch ||
              evt_bus.slices_held != want.held || evt_bus.last != want.last) begin
            report_mismatch($sformatf(
              "event res=%0d ch=%0d held=%0d last=%0b, expected res=%0d ch=%0d held=%0d last=%0b",
              evt_bus.event_res, evt_bus.event_channel, evt_bus.slices_held, evt_bus.last,
              want.ev, want.ch, want.held, want.last));
          end
        end
        sink_stall = draw_wait(sink_calm);
      end
      if (!holdoff_done && events_seen >= HOLDOFF_AFTER) begin
        holdoff_done = 1'b1;
        hold_left = HOLDOFF_CYCLES;
      end
      sink_holding = (hold_left != 0);
      if (hold_left != 0) begin
        hold_left--;
        evt_bus.ready <= 1'b0;
      end else if (sink_stall != 0) begin
        sink_stall--;
        evt_bus.ready <= 1'b0;
      end else begin
        evt_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n               = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.head_word   = '0;
    req_bus.tail_byte   = '0;
    req_bus.channel     = '0;
    req_bus.slice_index = '0;
    req_bus.slice_total = '0;
    req_bus.time_ms     = '0;
    evt_bus.ready       = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    cfg_head_magic      = '0;
    cfg_tail_magic      = '0;
    cfg_timeout_ms      = frt_pkg::TIMEOUT_RST;
    for (int c = 0; c < frt_pkg::CHANNELS_DEF; c++) begin
      seen_map[c]    = '0;
      held_cnt[c]    = '0;
      frame_total[c] = '0;
      last_time[c]   = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    apply_settings(16'h0000, 8'h00, 16'd80);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd0, 16'd0, 16'd1, 32'd100);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd255, 16'd63, 16'd2, 32'd0);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd255, 16'd1, 16'd2, 32'd80);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd255, 16'd64, 16'd2, 32'd90);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd7, 16'd3, 16'd4, 32'd1000);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd7, 16'hFFFF, 16'd4, 32'd1001);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd7, 16'd3, 16'd4, 32'd1002);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd7, 16'd1, 16'd4, 32'd1083);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd7, 16'd2, 16'd5, 32'd1084);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd7, 16'd0, 16'd5, 32'd1085);
    queue_packet(cfg_head_magic ^ 16'h0001, cfg_tail_magic, 8'd7, 16'd1, 16'd5, 32'd1086);
    queue_packet(cfg_head_magic, cfg_tail_magic ^ 8'h80, 8'd7, 16'd1, 16'd5, 32'd1086);
    for (int s = 1; s <= 4; s++) begin
      queue_packet(cfg_head_magic, cfg_tail_magic, 8'd7, 16'(s), 16'd5, 32'(1086 + s));
    end
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd9, 16'd5, 16'd2, 32'd0);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd9, 16'd0, 16'd1, 32'd10);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd10, 16'd1, 16'd0, 32'd0);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd10, 16'd2, 16'd3, 32'd1);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd10, 16'd3, 16'd3, 32'd2);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd11, 16'd1, 16'd100, 32'd5);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd11, 16'd2, 16'd100, 32'd6);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd11, 16'd0, 16'd100, 32'd7);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd12, 16'd1, 16'd3, 32'hFFFF_FFF0);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd12, 16'd2, 16'd3, 32'h0000_0010);
    queue_packet(cfg_head_magic, cfg_tail_magic, 8'd12, 16'd3, 16'd3, 32'h0000_0070);
    queue_random_phase(RANDOM_PER_PHASE);
    wait_idle();

    apply_settings(16'hFFFF, 8'hFF, 16'd0);
    queue_random_phase(RANDOM_PER_PHASE);
    wait_idle();

    apply_settings(16'($urandom), 8'($urandom), 16'hFFFF);
    queue_random_phase(RANDOM_PER_PHASE);
    wait_idle();

    apply_settings(16'($urandom), 8'($urandom), 16'($urandom_range(1, 300)));
    queue_random_phase(RANDOM_PER_PHASE);
    wait_idle();

    if (pending_events.size() != 0) begin
      report_mismatch($sformatf("%0d expected events never arrived", pending_events.size()));
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/frt_pkg.sv
rtl/core/frt_if.sv
rtl/core/frt_fifo.sv
rtl/core/frt_front.sv
rtl/core/frt_back.sv
rtl/core/fragment_reassembly_tracker.sv
tb/sv/fragment_reassembly_tracker_test.sv
